// ===== src/tcaof_pkg.sv =====
`default_nettype none
package tcaof_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int STAMP_WIDTH = 16;
  localparam int ID_WIDTH    = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;

  typedef enum logic [1:0] {
    CMD_ARRIVE    = 2'd0,
    CMD_ADOPT_ANY = 2'd1,
    CMD_ADOPT_A   = 2'd2,
    CMD_ADOPT_B   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_ADOPTED  = 2'd1,
    ST_NOTHING  = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_flags_t;

endpackage
`default_nettype wire

// ===== src/tcaof_if.sv =====
`default_nettype none
interface tcaof_req_if import tcaof_pkg::*; ;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 cmd;
  logic signed [ID_WIDTH-1:0] animal_id;

  modport source (output valid, output cmd, output animal_id, input ready);
  modport sink (input valid, input cmd, input animal_id, output ready);
endinterface

interface tcaof_rsp_if import tcaof_pkg::*; ;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic signed [ID_WIDTH-1:0] adopted_id;

  modport source (output valid, output status, output adopted_id, input ready);
  modport sink (input valid, input status, input adopted_id, output ready);
endinterface
`default_nettype wire

// ===== src/tcaof_queue.sv =====
`default_nettype none
module tcaof_queue
  import tcaof_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire logic signed [ID_WIDTH-1:0]    push_id,
  input  wire logic [STAMP_WIDTH-1:0]        push_stamp,
  input  wire logic                          pop,
  output q_flags_t                           flags,
  output logic signed [ID_WIDTH-1:0]         head_id,
  output logic [STAMP_WIDTH-1:0]             head_stamp
);

  logic signed [ID_WIDTH-1:0] ids [QUEUE_DEPTH];
  logic [STAMP_WIDTH-1:0]     stamps [QUEUE_DEPTH];
  logic [IDX_W-1:0]           head;
  logic [CNT_W-1:0]           count;
  logic [SUM_W-1:0]           tail_sum;
  logic [IDX_W-1:0]           tail;

  // tail slot wraps past the end of the ring
  always_comb begin
    tail_sum = SUM_W'(head) + SUM_W'(count);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
    end
    tail = tail_sum[IDX_W-1:0];
  end

  assign flags.empty = (count == '0);
  assign flags.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign head_id     = ids[head];
  assign head_stamp  = stamps[head];

  always_ff @(posedge clk) begin
    if (push) begin
      ids[tail]    <= push_id;
      stamps[tail] <= push_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (push) begin
      count <= count + CNT_W'(1);
    end else if (pop) begin
      count <= count - CNT_W'(1);
      if (head == IDX_W'(QUEUE_DEPTH - 1)) begin
        head <= '0;
      end else begin
        head <= head + IDX_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/two_class_age_ordered_fifo.sv =====
`default_nettype none
// a word waits in the input register, then its result is registered in the result register
// throughput: one word per cycle unless stalled; each word is one push or pop and one head-stamp compare
// the result register frees the input register whenever the result side takes or is empty
// reset clears the valid flags, head pointers, fill counts and the stamp counter;
// queue entries hold no reset value and are only read once written
module two_class_age_ordered_fifo
  import tcaof_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst,
  tcaof_req_if.sink  request,
  tcaof_rsp_if.source response
);

  logic                       s1_valid;
  cmd_t                       s1_cmd;
  logic signed [ID_WIDTH-1:0] s1_id;
  logic                       advance;

  logic                       out_valid;
  status_t                    out_status;
  logic signed [ID_WIDTH-1:0] out_id;

  logic [STAMP_WIDTH-1:0]     stamp_counter;

  q_flags_t                   a_flags;
  q_flags_t                   b_flags;
  logic signed [ID_WIDTH-1:0] a_head_id;
  logic signed [ID_WIDTH-1:0] b_head_id;
  logic [STAMP_WIDTH-1:0]     a_head_stamp;
  logic [STAMP_WIDTH-1:0]     b_head_stamp;
  logic [STAMP_WIDTH-1:0]     stamp_diff;
  logic                       b_older;
  logic                       positive;

  logic                       push_a;
  logic                       push_b;
  logic                       pop_a;
  logic                       pop_b;
  status_t                    status_next;
  logic signed [ID_WIDTH-1:0] id_next;

  assign advance          = s1_valid && (!out_valid || response.ready);
  assign request.ready    = !s1_valid || advance;
  assign response.valid   = out_valid;
  assign response.status  = out_status;
  assign response.adopted_id = out_id;

  // wrap-safe age compare, equal stamps go to class a
  assign stamp_diff = a_head_stamp - b_head_stamp;
  assign b_older    = (stamp_diff != '0) && !stamp_diff[STAMP_WIDTH-1];
  assign positive   = (s1_id != '0) && !s1_id[ID_WIDTH-1];

  always_comb begin
    push_a      = 1'b0;
    push_b      = 1'b0;
    pop_a       = 1'b0;
    pop_b       = 1'b0;
    status_next = ST_NOTHING;
    unique case (s1_cmd)
      CMD_ARRIVE: begin
        if (positive) begin
          push_a      = !a_flags.full;
          status_next = a_flags.full ? ST_FULL : ST_ACCEPTED;
        end else begin
          push_b      = !b_flags.full;
          status_next = b_flags.full ? ST_FULL : ST_ACCEPTED;
        end
      end
      CMD_ADOPT_ANY: begin
        if (!a_flags.empty && !b_flags.empty) begin
          pop_a = !b_older;
          pop_b = b_older;
        end else begin
          pop_a = !a_flags.empty;
          pop_b = !b_flags.empty;
        end
      end
      CMD_ADOPT_A: pop_a = !a_flags.empty;
      CMD_ADOPT_B: pop_b = !b_flags.empty;
      default: ;
    endcase
    if (pop_a || pop_b) begin
      status_next = ST_ADOPTED;
    end
    id_next = pop_a ? a_head_id : (pop_b ? b_head_id : '0);
  end

  tcaof_queue u_queue_a (
    .clk        (clk),
    .rst        (rst),
    .push       (advance && push_a),
    .push_id    (s1_id),
    .push_stamp (stamp_counter),
    .pop        (advance && pop_a),
    .flags      (a_flags),
    .head_id    (a_head_id),
    .head_stamp (a_head_stamp)
  );

  tcaof_queue u_queue_b (
    .clk        (clk),
    .rst        (rst),
    .push       (advance && push_b),
    .push_id    (s1_id),
    .push_stamp (stamp_counter),
    .pop        (advance && pop_b),
    .flags      (b_flags),
    .head_id    (b_head_id),
    .head_stamp (b_head_stamp)
  );

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      s1_cmd <= cmd_t'(request.cmd);
      s1_id  <= request.animal_id;
    end
    if (advance) begin
      out_status <= status_next;
      out_id     <= id_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      stamp_counter <= '0;
    end else begin
      if (request.ready) begin
        s1_valid <= request.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (response.ready) begin
        out_valid <= 1'b0;
      end
      // stamp moves on every arrival, dropped or not
      if (advance && s1_cmd == CMD_ARRIVE) begin
        stamp_counter <= stamp_counter + STAMP_WIDTH'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== test/tb_two_class_age_ordered_fifo.sv =====
`default_nettype none
module tb_two_class_age_ordered_fifo;
  import tcaof_pkg::*;

  localparam int HOLD_CYCLES = 80;

  class shelter_book;
    typedef struct {
      logic signed [ID_WIDTH-1:0] id;
      logic [STAMP_WIDTH-1:0]     stamp;
    } resident_t;

    typedef struct {
      status_t                    st;
      logic signed [ID_WIDTH-1:0] id;
    } outcome_t;

    resident_t              pen_a[$];
    resident_t              pen_b[$];
    outcome_t               owed[$];
    logic [STAMP_WIDTH-1:0] next_stamp;
    int                     errors;
    int                     words;
    int                     stamp_wraps;
    int                     by_status[4];

    function new();
      next_stamp  = '0;
      errors      = 0;
      words       = 0;
      stamp_wraps = 0;
      for (int i = 0; i < 4; i++) by_status[i] = 0;
    endfunction

    function int outstanding();
      return owed.size();
    endfunction

    // works out the outcome of one accepted command and queues it
    function void take_command(cmd_t c, logic signed [ID_WIDTH-1:0] id);
      outcome_t               res;
      resident_t              r;
      logic [STAMP_WIDTH-1:0] gap;
      int                     src;
      res.st = ST_NOTHING;
      res.id = '0;
      src    = 0;
      words++;
      case (c)
        CMD_ARRIVE: begin
          r.id    = id;
          r.stamp = next_stamp;
          // zero is not positive, so it lands in class b
          if (id > 0) begin
            if (pen_a.size() < QUEUE_DEPTH) begin
              pen_a.insert(pen_a.size(), r);
              res.st = ST_ACCEPTED;
            end else res.st = ST_FULL;
          end else begin
            if (pen_b.size() < QUEUE_DEPTH) begin
              pen_b.insert(pen_b.size(), r);
              res.st = ST_ACCEPTED;
            end else res.st = ST_FULL;
          end
          next_stamp = next_stamp + 1'b1;
          if (next_stamp == '0) stamp_wraps++;
        end
        CMD_ADOPT_ANY: begin
          if (pen_a.size() != 0 && pen_b.size() != 0) begin
            // modular age compare, ties go to class a
            gap = pen_a[0].stamp - pen_b[0].stamp;
            src = (gap != '0 && !gap[STAMP_WIDTH-1]) ? 2 : 1;
          end else if (pen_a.size() != 0) src = 1;
          else if (pen_b.size() != 0) src = 2;
        end
        CMD_ADOPT_A: if (pen_a.size() != 0) src = 1;
        default:     if (pen_b.size() != 0) src = 2;
      endcase
      if (src == 1) begin
        r      = pen_a.pop_front();
        res.st = ST_ADOPTED;
        res.id = r.id;
      end else if (src == 2) begin
        r      = pen_b.pop_front();
        res.st = ST_ADOPTED;
        res.id = r.id;
      end
      by_status[res.st]++;
      owed.insert(owed.size(), res);
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task match_outcome(logic [1:0] st, logic signed [ID_WIDTH-1:0] id);
      outcome_t want;
      if (owed.size() == 0) begin
        report($sformatf("unexpected word status=%0d id=%0d", st, id));
      end else begin
        want = owed.pop_front();
        if (st !== want.st)
          report($sformatf("status %0d, wanted %0d", st, want.st));
        if (id !== want.id)
          report($sformatf("adopted_id %0d, wanted %0d", id, want.id));
      end
    endtask
  endclass

  logic clk;
  logic rst;

  tcaof_req_if request_ch();
  tcaof_rsp_if response_ch();

  two_class_age_ordered_fifo dut (
    .clk      (clk),
    .rst      (rst),
    .request  (request_ch),
    .response (response_ch)
  );

  shelter_book book;
  int          send_idle_pct;
  int          take_idle_pct;
  bit          hold_wanted;
  int          hold_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    response_ch.ready = 1'b0;
    hold_left         = 0;
    forever begin
      @(negedge clk);
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        response_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        response_ch.ready <= ($urandom_range(99) >= take_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && response_ch.valid && response_ch.ready)
      book.match_outcome(response_ch.status, response_ch.adopted_id);
  end

  // entered and left at a falling edge
  task automatic send_word(cmd_t c, logic signed [ID_WIDTH-1:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      request_ch.valid <= 1'b0;
      @(negedge clk);
    end
    request_ch.valid     <= 1'b1;
    request_ch.cmd       <= c;
    request_ch.animal_id <= id;
    do @(posedge clk); while (!request_ch.ready);
    book.take_command(c, id);
    @(negedge clk);
  endtask

  function automatic logic signed [ID_WIDTH-1:0] pick_id();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 16'sh7fff;
      2:       return 16'sh8000;
      3:       return 16'sh0001;
      4:       return 16'shffff;
      default: return $signed(ID_WIDTH'($urandom));
    endcase
  endfunction

  // runs of twenty words, each run leaning towards filling, draining or neither
  task automatic random_words(int n);
    int   arrive_pct;
    cmd_t c;
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) begin
        case ($urandom_range(2))
          0:       arrive_pct = 50;
          1:       arrive_pct = 85;
          default: arrive_pct = 20;
        endcase
      end
      if ($urandom_range(99) < arrive_pct) c = CMD_ARRIVE;
      else c = cmd_t'($urandom_range(1, 3));
      send_word(c, pick_id());
    end
  endtask

  initial begin
    book                 = new();
    rst                  = 1'b1;
    request_ch.valid     = 1'b0;
    request_ch.cmd       = CMD_ARRIVE;
    request_ch.animal_id = '0;
    hold_wanted          = 1'b0;
    send_idle_pct        = 13;
    take_idle_pct        = 70;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty pens, class split on sign and zero, oldest-first order
    send_word(CMD_ADOPT_ANY, 16'sh1234);
    send_word(CMD_ADOPT_A, 16'sh0000);
    send_word(CMD_ARRIVE, 16'sh0000);
    send_word(CMD_ARRIVE, 16'sh7fff);
    send_word(CMD_ARRIVE, 16'sh8000);
    send_word(CMD_ADOPT_ANY, 16'shffff);
    send_word(CMD_ADOPT_ANY, 16'sh0000);
    send_word(CMD_ADOPT_ANY, 16'sh0000);
    send_word(CMD_ARRIVE, 16'sh0001);
    send_word(CMD_ADOPT_B, 16'sh5555);
    send_word(CMD_ADOPT_A, 16'shaaaa);
    send_word(CMD_ARRIVE, 16'shffff);
    // fill class a to the brim and one more
    for (int k = 0; k <= QUEUE_DEPTH; k++)
      send_word(CMD_ARRIVE, ID_WIDTH'(16'sh0100 + k));

    hold_wanted = 1'b1;
    random_words(220);

    send_idle_pct = 70;
    take_idle_pct = 13;
    hold_wanted   = 1'b1;
    random_words(220);

    send_idle_pct = 0;
    take_idle_pct = 0;
    random_words(210);

    request_ch.valid <= 1'b0;
    while (book.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("covered %0d words: %0d accepted, %0d adopted, %0d empty adopts, %0d dropped",
             book.words, book.by_status[ST_ACCEPTED], book.by_status[ST_ADOPTED],
             book.by_status[ST_NOTHING], book.by_status[ST_FULL]);
    $display("stamp counter wrapped %0d time(s); %0d mismatch(es)",
             book.stamp_wraps, book.errors);
    if (book.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
